@@ hw/rtl/sactl_pkg.sv @@
// shared types, constants and functions for the cache tag lookup unit
package sactl_pkg;

  localparam int unsigned BlocksDefault = 1024;
  localparam int unsigned AddrW = 32;
  localparam int unsigned TagW = 27;
  localparam int unsigned AgeW = 32;
  localparam int unsigned WayW = 10;
  localparam int unsigned CntW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 4;
  localparam logic [15:0] LfsrTaps = 16'hB400;
  localparam logic [15:0] LfsrSeed = 16'h0001;

  localparam logic [1:0] PolFifo = 2'd0;
  localparam logic [1:0] PolLru = 2'd1;
  localparam logic [1:0] PolRand = 2'd2;

  localparam logic [CfgIdxW-1:0] RegPolicy = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWays = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBlocks = 2'd2;
  localparam logic [CfgIdxW-1:0] RegOffset = 2'd3;

  typedef enum logic [1:0] {
    OpNone, OpClr, OpInc, OpLoad
  } cnt_op_e;

  // controller to datapath
  typedef struct packed {
    logic    latch;      // capture address geometry, clear scan flags
    logic    rd;         // issue read of entry base + cnt
    cnt_op_e cnt_op;
    logic    scan;       // evaluate returned read for hit, invalid and victim
    logic    decide;     // fix the accessed way
    logic    wr_fill;    // write tag, valid and fifo stamp of the accessed way
    logic    lru_age;    // write updated rank of returned read
    logic    commit;     // update totals, present result
  } sactl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;          // cnt is last way
    logic hit;
    logic is_lru;
  } sactl_sts_t;

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    lfsr_next = v[0] ? ((v >> 1) ^ LfsrTaps) : (v >> 1);
  endfunction

endpackage

@@ hw/rtl/sactl_ram.sv @@
// generic simple dual-port ram (one write port, one read port) with registered read
module sactl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule

@@ hw/rtl/sactl_ctrl.sv @@
// controller state machine for the lookup sequence
module sactl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  clr_done_i,
  output logic                  busy_o,
  output sactl_pkg::sactl_cmd_t cmd_o,
  input  sactl_pkg::sactl_sts_t sts_i
);
  import sactl_pkg::*;

  typedef enum logic [8:0] {
    SClr    = 9'b000000001,
    SIdle   = 9'b000000010,
    SScan   = 9'b000000100,
    SScanW  = 9'b000001000,
    SDecide = 9'b000010000,
    SFill   = 9'b000100000,
    SAgeW   = 9'b001000000,
    SAgeUp  = 9'b010000000,
    SDone   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.cnt_op = OpNone;
    case (state_q)
      SClr: if (clr_done_i) state_d = SIdle;
      SIdle: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          cmd_o.cnt_op = OpClr;
          state_d = SScan;
        end
      end
      SScan: begin
        cmd_o.rd = 1'b1;
        state_d = SScanW;
      end
      SScanW: begin
        // read data of current way is valid now
        cmd_o.scan = 1'b1;
        if (sts_i.hit || sts_i.last) begin
          state_d = SDecide;
        end else begin
          cmd_o.cnt_op = OpInc;
          state_d = SScan;
        end
      end
      SDecide: begin
        cmd_o.decide = 1'b1;
        if (sts_i.hit) begin
          cmd_o.cnt_op = OpClr;
          state_d = sts_i.is_lru ? SAgeW : SDone;
        end else begin
          cmd_o.cnt_op = OpLoad;
          state_d = SFill;
        end
      end
      SFill: begin
        cmd_o.wr_fill = 1'b1;
        if (sts_i.is_lru) begin
          cmd_o.cnt_op = OpClr;
          state_d = SAgeW;
        end else begin
          state_d = SDone;
        end
      end
      SAgeW: begin
        cmd_o.rd = 1'b1;
        state_d = SAgeUp;
      end
      SAgeUp: begin
        cmd_o.lru_age = 1'b1;
        if (sts_i.last) begin
          state_d = SDone;
        end else begin
          cmd_o.cnt_op = OpInc;
          state_d = SAgeW;
        end
      end
      SDone: begin
        cmd_o.commit = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end
endmodule

@@ hw/rtl/sactl_dp.sv @@
// datapath: geometry, stores, way scan, victim choice, counters
module sactl_dp #(
  parameter int unsigned Blocks = sactl_pkg::BlocksDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sactl_pkg::sactl_cmd_t        cmd_i,
  output sactl_pkg::sactl_sts_t        sts_o,
  output logic                         clr_done_o,
  input  logic                         cfg_we_i,
  input  logic [sactl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sactl_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [sactl_pkg::AddrW-1:0]  address_i,
  output logic                         valid_o,
  output logic                         hit_o,
  output logic [sactl_pkg::WayW-1:0]   way_o,
  output logic                         evicted_o,
  output logic [sactl_pkg::CntW-1:0]   hit_total_o,
  output logic [sactl_pkg::CntW-1:0]   miss_total_o
);
  import sactl_pkg::*;

  localparam int unsigned IdxW = $clog2(Blocks);
  localparam logic [3:0] MaxLog = 4'($clog2(Blocks + 1) - 1);
  localparam int unsigned EntW = 1 + TagW;

  logic [1:0] policy_q;
  logic [3:0] ways_q, bcl_q;
  logic [2:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolFifo;
      ways_q   <= 4'd0;
      bcl_q    <= 4'd4;
      off_q    <= 3'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPolicy: policy_q <= cfg_data_i[1:0];
        RegWays:   ways_q   <= cfg_data_i;
        RegBlocks: bcl_q    <= cfg_data_i;
        RegOffset: off_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [3:0] bcl, wl, sbits;
  logic [2:0] ob;
  always_comb begin
    bcl = (bcl_q < 4'd4) ? 4'd4 : bcl_q;
    if (bcl > MaxLog) bcl = MaxLog;
    wl = (ways_q > bcl) ? bcl : ways_q;
    ob = (off_q < 3'd5) ? 3'd5 : ((off_q > 3'd6) ? 3'd6 : off_q);
    sbits = bcl - wl;
  end

  logic is_lru, is_rand, is_fifo;
  assign is_lru  = (policy_q == PolLru);
  assign is_rand = (policy_q == PolRand);
  assign is_fifo = !is_lru && !is_rand;

  logic [IdxW-1:0]  setv;
  logic [TagW-1:0]  tagv;
  logic [AddrW-1:0] sh;
  logic [WayW-1:0]  wmask;

  always_comb begin
    sh    = address_i >> ob;
    setv  = IdxW'(sh & ((AddrW'(1) << sbits) - AddrW'(1)));
    tagv  = TagW'(sh >> sbits);
    wmask = WayW'((11'd1 << wl) - 11'd1);
  end

  // clearing pass
  logic            clr_q;
  logic [IdxW-1:0] clr_idx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == IdxW'(Blocks - 1)) clr_q <= 1'b0;
    end
  end
  assign clr_done_o = !clr_q;

  // state of the current item
  logic [IdxW-1:0] base_q;
  logic [TagW-1:0] tag_q;
  logic [WayW-1:0] wmask_q, cnt_q, acc_q, inv_way_q, vic_way_q;
  logic            hit_q, inv_q, evict_q;
  logic [AgeW-1:0] hit_age_q, inv_age_q, vic_age_q, old_rank_q;
  logic [AgeW-1:0] arr_q;
  logic [15:0]     lfsr_q;
  logic [CntW-1:0] hits_q, miss_q;

  logic [IdxW-1:0] raddr, waddr;
  logic            we_ent, we_age;
  logic [EntW-1:0] wd_ent, rd_ent;
  logic [AgeW-1:0] wd_age, rd_age;
  assign raddr = base_q | IdxW'(cnt_q);

  sactl_ram #(.Width(EntW), .Depth(Blocks)) u_ent (
    .clk_i, .we_i(we_ent), .waddr_i(waddr), .wdata_i(wd_ent),
    .re_i(cmd_i.rd), .raddr_i(raddr), .rdata_o(rd_ent)
  );
  sactl_ram #(.Width(AgeW), .Depth(Blocks)) u_age (
    .clk_i, .we_i(we_age), .waddr_i(waddr), .wdata_i(wd_age),
    .re_i(cmd_i.rd), .raddr_i(raddr), .rdata_o(rd_age)
  );

  logic rd_valid, rd_match, vic_better, lfsr_step;

  assign rd_valid = rd_ent[EntW-1];
  assign rd_match = rd_valid && (rd_ent[TagW-1:0] == tag_q);
  assign vic_better = (cnt_q == '0) ||
                      (is_lru ? (rd_age > vic_age_q) : (rd_age < vic_age_q));
  assign lfsr_step = cmd_i.decide && !hit_q && !inv_q && is_rand;

  logic [15:0] lfsr_n;
  assign lfsr_n = lfsr_next(lfsr_q);

  // accessed way after the scan
  logic [WayW-1:0] acc_sel;
  always_comb begin
    if (hit_q)        acc_sel = cnt_q;
    else if (inv_q)   acc_sel = inv_way_q;
    else if (is_rand) acc_sel = WayW'(lfsr_n) & wmask_q;
    else              acc_sel = vic_way_q;
  end

  always_comb begin
    we_ent = 1'b0;
    we_age = 1'b0;
    waddr  = raddr;
    wd_ent = {1'b1, tag_q};
    wd_age = arr_q;
    if (clr_q) begin
      we_ent = 1'b1;
      we_age = 1'b1;
      waddr  = clr_idx_q;
      wd_ent = '0;
      wd_age = '0;
    end else if (cmd_i.wr_fill) begin
      we_ent = 1'b1;
      we_age = is_fifo;
    end else if (cmd_i.lru_age) begin
      we_age = 1'b1;
      if (cnt_q == acc_q) wd_age = AgeW'(1);
      else if (rd_age != '0 && (old_rank_q == '0 || rd_age < old_rank_q))
        wd_age = rd_age + AgeW'(1);
      else wd_age = rd_age;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      tag_q        <= '0;
      wmask_q      <= '0;
      cnt_q        <= '0;
      acc_q        <= '0;
      inv_way_q    <= '0;
      vic_way_q    <= '0;
      hit_q        <= 1'b0;
      inv_q        <= 1'b0;
      evict_q      <= 1'b0;
      hit_age_q    <= '0;
      inv_age_q    <= '0;
      vic_age_q    <= '0;
      old_rank_q   <= '0;
      arr_q        <= '0;
      lfsr_q       <= LfsrSeed;
      hits_q       <= '0;
      miss_q       <= '0;
      valid_o      <= 1'b0;
      hit_o        <= 1'b0;
      way_o        <= '0;
      evicted_o    <= 1'b0;
      hit_total_o  <= '0;
      miss_total_o <= '0;
    end else begin
      valid_o <= cmd_i.commit;
      if (cmd_i.latch) begin
        base_q  <= IdxW'(setv << wl);
        tag_q   <= tagv;
        wmask_q <= wmask;
        hit_q   <= 1'b0;
        inv_q   <= 1'b0;
      end
      case (cmd_i.cnt_op)
        OpClr:  cnt_q <= '0;
        OpInc:  cnt_q <= cnt_q + 1'b1;
        OpLoad: cnt_q <= acc_sel;
        default: ;
      endcase
      if (cmd_i.scan) begin
        if (rd_match) begin
          hit_q     <= 1'b1;
          hit_age_q <= rd_age;
        end
        if (!rd_valid && !inv_q) begin
          inv_q     <= 1'b1;
          inv_way_q <= cnt_q;
          inv_age_q <= rd_age;
        end
        if (vic_better) begin
          vic_age_q <= rd_age;
          vic_way_q <= cnt_q;
        end
      end
      if (cmd_i.decide) begin
        acc_q      <= acc_sel;
        old_rank_q <= hit_q ? hit_age_q : (inv_q ? inv_age_q : vic_age_q);
        evict_q    <= !hit_q && !inv_q;
      end
      if (lfsr_step) lfsr_q <= lfsr_n;
      if (cmd_i.wr_fill && is_fifo) arr_q <= arr_q + AgeW'(1);
      if (cmd_i.commit) begin
        if (hit_q) hits_q <= hits_q + 1'b1;
        else       miss_q <= miss_q + 1'b1;
        hit_o        <= hit_q;
        way_o        <= acc_q;
        evicted_o    <= evict_q;
        hit_total_o  <= hit_q ? hits_q + 1'b1 : hits_q;
        miss_total_o <= hit_q ? miss_q : miss_q + 1'b1;
      end
    end
  end

  assign sts_o.last   = (cnt_q == wmask_q);
  assign sts_o.hit    = hit_q || (cmd_i.scan && rd_match);
  assign sts_o.is_lru = is_lru;
endmodule

@@ hw/rtl/set_associative_cache_tag_lookup_unit.sv @@
// top level of the set-associative cache tag lookup unit
// Give one 32-bit address with start while busy is low; one result follows
// on the one-cycle done_o strobe, in the first cycle with busy low, and must
// be taken then since it cannot be stalled. Each way of the set costs one ram
// read and one compare step (SScan, SScanW); the scan stops at a hit or at the
// last way, a miss then writes the fill, and under LRU a rank update pass reads
// and rewrites the rank of every way of the set. A new item can be started in
// the cycle of the strobe. After reset a clearing pass over all Blocks entries
// runs with busy high. cfg_ready_o is low while busy or start is high, so a
// register write never lands in the middle of an item.
module set_associative_cache_tag_lookup_unit #(
  parameter int unsigned Blocks = sactl_pkg::BlocksDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [sactl_pkg::AddrW-1:0]  address_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [sactl_pkg::WayW-1:0]   way_o,
  output logic                         evicted_o,
  output logic [sactl_pkg::CntW-1:0]   hit_total_o,
  output logic [sactl_pkg::CntW-1:0]   miss_total_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sactl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sactl_pkg::CfgDataW-1:0] cfg_data_i
);
  import sactl_pkg::*;

  sactl_cmd_t cmd;
  sactl_sts_t sts;
  logic       clr_done;

  assign cfg_ready_o = !busy && !start;

  sactl_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .clr_done_i(clr_done),
    .busy_o(busy), .cmd_o(cmd), .sts_i(sts)
  );

  sactl_dp #(.Blocks(Blocks)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .clr_done_o(clr_done),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_idx_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .address_i(address_i), .valid_o(done_o),
    .hit_o, .way_o, .evicted_o, .hit_total_o, .miss_total_o
  );

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> busy) else $error("commit while idle");
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_o)) else $error("evict on hit");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !busy) else $error("config write while busy");
`endif
endmodule
